### design/sia_pkg.sv
// Shared types and constants of the slot id allocator.
`default_nettype none

package sia_pkg;

  localparam int SLOTS_PER_BLOCK = 64;
  localparam int BLOCK_COUNT     = 16;
  localparam int POOL_SIZE       = SLOTS_PER_BLOCK * BLOCK_COUNT;

  // Ids run from 1 to POOL_SIZE; an id field also holds 0 (invalid).
  localparam int ID_W  = 11;
  // A table index holds (id - 1).
  localparam int IDX_W = $clog2(POOL_SIZE);

  localparam logic [ID_W-1:0] POOL_ID = ID_W'(POOL_SIZE);
  localparam logic [ID_W-1:0] ID_ONE  = ID_W'(1);

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_LOOKUP  = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // Capture the request and launch the table reads.
    logic exec;    // Apply the update and load the response register.
  } cmd_t;

endpackage

`default_nettype wire

### design/sia_req_if.sv
// Request channel: operation code and slot id with a valid/ready handshake.
`default_nettype none

interface sia_req_if;
  logic                        valid;
  logic                        ready;
  sia_pkg::func_t              func;
  logic [sia_pkg::ID_W-1:0]    slot_id;

  modport source (output valid, output func, output slot_id, input ready);
  modport sink   (input valid, input func, input slot_id, output ready);
endinterface

`default_nettype wire

### design/sia_rsp_if.sv
// Response channel: result id, success flag and live count with a valid/ready handshake.
`default_nettype none

interface sia_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [sia_pkg::ID_W-1:0]    result_id;
  logic                        ok;
  logic [sia_pkg::ID_W-1:0]    live_count;

  modport source (output valid, output result_id, output ok, output live_count, input ready);
  modport sink   (input valid, input result_id, input ok, input live_count, output ready);
endinterface

`default_nettype wire

### design/slot_id_allocator.sv
// Top level of the slot id allocator: controller, datapath and channel wiring.
// Flow: a request accepted in the idle state moves the controller to the execute
//   state, which loads the response register once that register is free.
// Issue: a request is taken only after the previous one has executed; the
//   registered read of the free stack and live map memories must complete first.
// Reset: synchronous, active low; counters return to empty with no memory sweep.
`default_nettype none

module slot_id_allocator (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sia_req_if.sink    in_req,
  sia_rsp_if.source  out_rsp
);

  // Each request takes two steps. In the first step the request transfer
  // captures the operation and id and launches reads of both memories: the
  // live map at (slot_id - 1) and the top of the free stack. In the second
  // step the datapath decides the outcome, writes at most one entry of each
  // memory and loads the response register.
  //
  // The live map needs no clearing pass. Ids are handed out from a bump
  // counter in increasing order, so every id below the counter has been
  // written since the last clear or reset, and anything at or above it is
  // treated as free. A clear therefore only resets the counters.
  //
  // The response register decouples the two channels: a new request is
  // taken while an earlier response waits, and the second step simply holds
  // until the response register is free.

  sia_pkg::cmd_t cmd;

  sia_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  sia_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_func        (in_req.func),
    .in_slot_id     (in_req.slot_id),
    .out_result_id  (out_rsp.result_id),
    .out_ok         (out_rsp.ok),
    .out_live_count (out_rsp.live_count)
  );

endmodule

`default_nettype wire

### design/sia_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module sia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rdata_r;

endmodule

`default_nettype wire

### design/sia_ctrl.sv
// Controller state machine: sequences each request through read and execute.
`default_nettype none

module sia_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sia_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   exec_fire;

  // No request is taken while reset is held.
  assign in_ready  = rst_n && (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  // The result may only be loaded once the response register is free.
  assign exec_fire = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign cmd.accept = accept;
  assign cmd.exec   = exec_fire;

  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted request did not move to execute");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_valid_r)
    else $error("executed request left no pending result");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> !accept)
    else $error("request accepted while another is executing");

endmodule

`default_nettype wire

### design/sia_dp.sv
// Datapath: live map and free stack memories, counters and the response register.
`default_nettype none

module sia_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sia_pkg::cmd_t               cmd,
  input  wire sia_pkg::func_t              in_func,
  input  wire logic [sia_pkg::ID_W-1:0]    in_slot_id,
  output logic      [sia_pkg::ID_W-1:0]    out_result_id,
  output logic                             out_ok,
  output logic      [sia_pkg::ID_W-1:0]    out_live_count
);

  localparam int ID_W  = sia_pkg::ID_W;
  localparam int IDX_W = sia_pkg::IDX_W;

  // Captured request.
  sia_pkg::func_t  func_r;
  logic [ID_W-1:0] id_r;

  // Allocator state.
  logic [ID_W-1:0] stack_depth_r, stack_depth_nxt;
  logic [ID_W-1:0] fresh_next_r, fresh_next_nxt;
  logic [ID_W-1:0] live_total_r, live_total_nxt;

  // Response register.
  logic [ID_W-1:0] res_r, res_nxt;
  logic            ok_r, ok_nxt;
  logic [ID_W-1:0] cnt_r;

  // Memory ports.
  logic [ID_W-1:0]  in_id_m1;
  logic [ID_W-1:0]  depth_m1;
  logic             live_rdata;
  logic [IDX_W-1:0] stack_rdata;
  logic             live_we, live_wdata;
  logic [IDX_W-1:0] live_waddr;
  logic             stack_we;

  logic [ID_W-1:0]  id_m1;
  logic [ID_W-1:0]  got_id;
  logic [ID_W-1:0]  got_m1;
  logic             id_valid;
  logic             id_live;
  logic             stack_nonempty;
  logic             can_alloc;

  assign in_id_m1 = in_slot_id - sia_pkg::ID_ONE;
  assign depth_m1 = stack_depth_r - sia_pkg::ID_ONE;

  // Every id below fresh_next has been written in the live map since the
  // last clear, so entries at or above it read as free without a sweep.
  sia_ram #(.WIDTH(1), .DEPTH(sia_pkg::POOL_SIZE)) u_live_map (
    .clk     (clk),
    .wr_en   (live_we),
    .wr_addr (live_waddr),
    .wr_data (live_wdata),
    .rd_en   (cmd.accept),
    .rd_addr (in_id_m1[IDX_W-1:0]),
    .rd_data (live_rdata)
  );

  sia_ram #(.WIDTH(IDX_W), .DEPTH(sia_pkg::POOL_SIZE)) u_free_stack (
    .clk     (clk),
    .wr_en   (stack_we),
    .wr_addr (stack_depth_r[IDX_W-1:0]),
    .wr_data (id_m1[IDX_W-1:0]),
    .rd_en   (cmd.accept),
    .rd_addr (depth_m1[IDX_W-1:0]),
    .rd_data (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_func;
      id_r   <= in_slot_id;
    end
  end

  assign id_m1          = id_r - sia_pkg::ID_ONE;
  assign id_valid       = (id_r != '0) && (id_r <= sia_pkg::POOL_ID);
  assign id_live        = id_valid && (id_r < fresh_next_r) && live_rdata;
  assign stack_nonempty = (stack_depth_r != '0);
  assign got_id         = stack_nonempty ? (ID_W'(stack_rdata) + sia_pkg::ID_ONE)
                                         : fresh_next_r;
  assign got_m1         = got_id - sia_pkg::ID_ONE;
  assign can_alloc      = (live_total_r < sia_pkg::POOL_ID)
                       && (stack_nonempty || (fresh_next_r <= sia_pkg::POOL_ID));

  always_comb begin
    stack_depth_nxt = stack_depth_r;
    fresh_next_nxt  = fresh_next_r;
    live_total_nxt  = live_total_r;
    res_nxt         = id_r;
    ok_nxt          = 1'b0;
    live_we         = 1'b0;
    live_wdata      = 1'b0;
    live_waddr      = id_m1[IDX_W-1:0];
    stack_we        = 1'b0;
    case (func_r)
      sia_pkg::FUNC_ALLOC: begin
        res_nxt = '0;
        if (can_alloc) begin
          res_nxt        = got_id;
          ok_nxt         = 1'b1;
          live_total_nxt = live_total_r + sia_pkg::ID_ONE;
          live_we        = 1'b1;
          live_wdata     = 1'b1;
          live_waddr     = got_m1[IDX_W-1:0];
          if (stack_nonempty) begin
            stack_depth_nxt = depth_m1;
          end else begin
            fresh_next_nxt = fresh_next_r + sia_pkg::ID_ONE;
          end
        end
      end
      sia_pkg::FUNC_RELEASE: begin
        if (id_live) begin
          ok_nxt  = 1'b1;
          live_we = 1'b1;
          if (live_total_r != '0) begin
            live_total_nxt = live_total_r - sia_pkg::ID_ONE;
          end
          if (stack_depth_r < sia_pkg::POOL_ID) begin
            stack_we        = 1'b1;
            stack_depth_nxt = stack_depth_r + sia_pkg::ID_ONE;
          end
        end
      end
      sia_pkg::FUNC_LOOKUP: begin
        ok_nxt = id_live;
      end
      sia_pkg::FUNC_CLEAR: begin
        stack_depth_nxt = '0;
        fresh_next_nxt  = sia_pkg::ID_ONE;
        live_total_nxt  = '0;
        ok_nxt          = 1'b1;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
    live_we  = live_we && cmd.exec;
    stack_we = stack_we && cmd.exec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_depth_r <= '0;
      fresh_next_r  <= sia_pkg::ID_ONE;
      live_total_r  <= '0;
    end else if (cmd.exec) begin
      stack_depth_r <= stack_depth_nxt;
      fresh_next_r  <= fresh_next_nxt;
      live_total_r  <= live_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r <= res_nxt;
      ok_r  <= ok_nxt;
      cnt_r <= live_total_nxt;
    end
  end

  assign out_result_id  = res_r;
  assign out_ok         = ok_r;
  assign out_live_count = cnt_r;

  // Every id handed out by the fresh counter is either live or on the stack.
  a_id_conservation: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, live_total_r} + {1'b0, stack_depth_r} + {1'b0, sia_pkg::ID_ONE})
      == {1'b0, fresh_next_r})
    else $error("live count and stack depth disagree with the fresh counter");

  a_live_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    live_total_r <= sia_pkg::POOL_ID)
    else $error("live count exceeds the pool size");

  a_failed_alloc_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (func_r == sia_pkg::FUNC_ALLOC) && !can_alloc)
      |=> $stable(live_total_r) && $stable(stack_depth_r) && $stable(fresh_next_r))
    else $error("failed allocate changed allocator state");

endmodule

`default_nettype wire

### verif/tb_slot_id_allocator.sv
// Self-checking testbench for the slot id allocator: directed, random and backpressure tests.
`default_nettype none

module tb_slot_id_allocator;
  import sia_pkg::*;

  // One response as the block reports it.
  typedef struct packed {
    logic [ID_W-1:0] result_id;
    logic            ok;
    logic [ID_W-1:0] live_count;
  } slot_rsp_t;

  logic clk;
  logic rst_n;
  logic stall_rsp = 1'b0;

  sia_req_if req_bus ();
  sia_rsp_if rsp_bus ();

  slot_id_allocator u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus),
    .out_rsp (rsp_bus)
  );

  // Shadow state of the allocator, updated at each accepted request.
  bit              slot_live [1:POOL_SIZE];
  logic [IDX_W-1:0] free_ids [POOL_SIZE];
  int              free_depth  = 0;
  int              fresh_id    = 1;
  int              live_total  = 0;

  slot_rsp_t due_rsp[$];
  int        mismatch_cnt  = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the shadow state and returns the response it must give.
  function automatic slot_rsp_t apply_slot_op(func_t f, logic [ID_W-1:0] id);
    slot_rsp_t r;
    int        got;
    bit        id_ok;
    r.result_id = id;
    r.ok        = 1'b0;
    id_ok       = (id != '0) && (id <= POOL_ID);
    case (f)
      FUNC_ALLOC: begin
        r.result_id = '0;
        if (live_total < POOL_SIZE) begin
          got = 0;
          if (free_depth > 0) begin
            free_depth--;
            got = int'(free_ids[free_depth]) + 1;
          end else if (fresh_id <= POOL_SIZE) begin
            got = fresh_id;
            fresh_id++;
          end
          if (got != 0 && got <= POOL_SIZE) begin
            slot_live[got] = 1'b1;
            live_total++;
            r.result_id = ID_W'(got);
            r.ok        = 1'b1;
          end
        end
      end
      FUNC_RELEASE: begin
        if (id_ok && slot_live[int'(id)]) begin
          slot_live[int'(id)] = 1'b0;
          if (live_total > 0) live_total--;
          if (free_depth < POOL_SIZE) begin
            free_ids[free_depth] = IDX_W'(id - ID_ONE);
            free_depth++;
          end
          r.ok = 1'b1;
        end
      end
      FUNC_LOOKUP: begin
        r.ok = id_ok && slot_live[int'(id)];
      end
      default: begin
        foreach (slot_live[i]) slot_live[i] = 1'b0;
        free_depth = 0;
        fresh_id   = 1;
        live_total = 0;
        r.ok       = 1'b1;
      end
    endcase
    r.live_count = ID_W'(live_total);
    return r;
  endfunction

  // Returns some live id, scanning from a random start, or 0 if none is live.
  function automatic logic [ID_W-1:0] pick_live_id();
    int start;
    int id;
    start = $urandom_range(1, POOL_SIZE);
    for (int k = 0; k < POOL_SIZE; k++) begin
      id = (start - 1 + k) % POOL_SIZE + 1;
      if (slot_live[id]) return ID_W'(id);
    end
    return '0;
  endfunction

  // Offers one request and waits for its transfer. Valid stays high afterwards so that
  // back-to-back requests need no second assignment in one time step.
  task automatic send_req(func_t f, logic [ID_W-1:0] id);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid   <= 1'b1;
    req_bus.func    <= f;
    req_bus.slot_id <= id;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    due_rsp = {due_rsp, apply_slot_op(f, id)};
  endtask

  // Drops valid and waits until every outstanding response has come back.
  task automatic hold_input_until_drained();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (due_rsp.size() != 0) @(posedge clk);
  endtask

  // One random request from a weighted mix; weights are percentages.
  task automatic send_random(int alloc_w, int rel_w, int look_w, int noise_w);
    int              r;
    logic [ID_W-1:0] id;
    r = $urandom_range(0, 99);
    if (r < alloc_w) begin
      send_req(FUNC_ALLOC, ID_W'($urandom));
    end else if (r < alloc_w + rel_w) begin
      id = pick_live_id();
      if (id == '0) send_req(FUNC_ALLOC, ID_W'($urandom));
      else send_req(FUNC_RELEASE, id);
    end else if (r < alloc_w + rel_w + look_w) begin
      if ($urandom_range(0, 1) != 0) send_req(FUNC_LOOKUP, pick_live_id());
      else send_req(FUNC_LOOKUP, ID_W'($urandom_range(0, POOL_SIZE + 1)));
    end else if (r < alloc_w + rel_w + look_w + noise_w) begin
      // Ids across the whole field width, mostly dead or out of range.
      if ($urandom_range(0, 1) != 0) send_req(FUNC_RELEASE, ID_W'($urandom));
      else send_req(FUNC_LOOKUP, ID_W'($urandom));
    end else begin
      send_req(FUNC_CLEAR, ID_W'($urandom));
    end
  endtask

  task automatic test_directed();
    send_req(FUNC_LOOKUP, '0);
    send_req(FUNC_LOOKUP, ID_ONE);
    send_req(FUNC_LOOKUP, POOL_ID);
    send_req(FUNC_LOOKUP, POOL_ID + ID_ONE);
    send_req(FUNC_LOOKUP, '1);
    send_req(FUNC_RELEASE, '0);
    send_req(FUNC_RELEASE, '1);
    send_req(FUNC_RELEASE, ID_ONE);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_LOOKUP, ID_W'(2));
    send_req(FUNC_RELEASE, ID_W'(2));
    // Releasing the same id twice: the second one hits a dead id.
    send_req(FUNC_RELEASE, ID_W'(2));
    send_req(FUNC_LOOKUP, ID_W'(2));
    send_req(FUNC_RELEASE, ID_ONE);
    send_req(FUNC_RELEASE, ID_W'(3));
    // The free stack is LIFO, so id 3 comes back first, then id 1, then id 2.
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_CLEAR, '1);
    send_req(FUNC_LOOKUP, ID_ONE);
    send_req(FUNC_ALLOC, '1);
    send_req(FUNC_RELEASE, POOL_ID + ID_ONE);
    send_req(FUNC_ALLOC, '0);
  endtask

  task automatic test_random_churn(int n);
    repeat (n) send_random(40, 28, 12, 17);
  endtask

  // Fills the pool mostly with allocations, then probes the full pool.
  task automatic test_fill_pool();
    send_req(FUNC_CLEAR, '0);
    while (live_total < POOL_SIZE) send_random(90, 4, 3, 3);
    repeat (4) send_req(FUNC_ALLOC, ID_W'($urandom));
    send_req(FUNC_LOOKUP, POOL_ID);
    send_req(FUNC_LOOKUP, ID_ONE);
    send_req(FUNC_LOOKUP, POOL_ID + ID_ONE);
    send_req(FUNC_RELEASE, pick_live_id());
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_ALLOC, '0);
  endtask

  // The receiver stalls for a long stretch while releases keep coming, so the
  // block backs up and holds off its input.
  task automatic test_rsp_backpressure();
    logic [ID_W-1:0] id;
    fork
      begin
        stall_rsp <= 1'b1;
        repeat (300) @(posedge clk);
        stall_rsp <= 1'b0;
      end
      begin
        repeat (40) begin
          id = pick_live_id();
          send_req((id != '0) ? FUNC_RELEASE : FUNC_ALLOC, id);
        end
      end
    join
  endtask

  // After a full drain, pops the deep free stack back out and then churns from empty.
  task automatic test_drain_and_refill();
    hold_input_until_drained();
    repeat (41) send_req(FUNC_ALLOC, ID_W'($urandom));
    send_req(FUNC_CLEAR, '0);
    test_random_churn(60);
  endtask

  // Response side: checks each transfer against the oldest prediction and
  // drives ready for the next cycle.
  initial begin
    slot_rsp_t want;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
        if (due_rsp.size() == 0) begin
          $error("response with none outstanding: result_id %0d ok %0b live_count %0d",
                 rsp_bus.result_id, rsp_bus.ok, rsp_bus.live_count);
          mismatch_cnt++;
        end else begin
          want = due_rsp.pop_front();
          if (rsp_bus.result_id !== want.result_id) begin
            $error("result_id: expected %0d, actual %0d", want.result_id, rsp_bus.result_id);
            mismatch_cnt++;
          end
          if (rsp_bus.ok !== want.ok) begin
            $error("ok: expected %0b, actual %0b", want.ok, rsp_bus.ok);
            mismatch_cnt++;
          end
          if (rsp_bus.live_count !== want.live_count) begin
            $error("live_count: expected %0d, actual %0d", want.live_count,
                   rsp_bus.live_count);
            mismatch_cnt++;
          end
        end
      end
      rsp_bus.ready <= !stall_rsp && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    int wait_cycles;
    req_bus.valid   <= 1'b0;
    req_bus.func    <= FUNC_ALLOC;
    req_bus.slot_id <= '0;
    rst_n           <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 8;
    recv_idle_pct = 59;
    test_directed();
    test_random_churn(180);

    send_idle_pct = 59;
    recv_idle_pct = 8;
    test_fill_pool();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_rsp_backpressure();
    test_drain_and_refill();

    req_bus.valid <= 1'b0;
    wait_cycles = 0;
    while (due_rsp.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4) @(posedge clk);
    if (due_rsp.size() != 0) begin
      $error("%0d responses never arrived", due_rsp.size());
      mismatch_cnt++;
    end

    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
